// ===== hdl/xsr_pkg.sv =====
`default_nettype none

package xsr_pkg;

  // Splitmix64 constants
  localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

  // Item modes
  localparam logic MODE_RESEED = 1'b0;
  localparam logic MODE_DRAW   = 1'b1;

  // Datapath operations issued by the controller
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LOAD_SEED = 4'd1;
  localparam logic [3:0] OP_LOAD_ZERO = 4'd2;
  localparam logic [3:0] OP_GAMMA     = 4'd3;
  localparam logic [3:0] OP_MUL0      = 4'd4;
  localparam logic [3:0] OP_MUL1      = 4'd5;
  localparam logic [3:0] OP_MUL2      = 4'd6;
  localparam logic [3:0] OP_FIN       = 4'd7;
  localparam logic [3:0] OP_DRAW      = 4'd8;

  typedef struct packed {
    logic        mode;
    logic [63:0] seed_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] random_word;
    logic [51:0] unit_fraction;
    logic        coin_bit;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic [3:0] op;
    logic       stage;     // 0: first mix multiply, 1: second
    logic [1:0] word_idx;  // state word being filled
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;        // result held and not taken this cycle
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/xsr_datapath.sv =====
`default_nettype none

module xsr_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire xsr_pkg::ctl_cmd_t cmd,
  output xsr_pkg::dp_sts_t       sts,
  input  wire logic [63:0]       seed_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output xsr_pkg::out_item_t     out_data
);

  logic [63:0] w_r [4];
  logic [63:0] ctr_r;
  logic [63:0] z_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [63:0] word_r;
  logic        out_valid_r;

  logic [63:0] ctr_nxt;
  logic [63:0] mul_const;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mix_sum;
  logic [63:0] draw_sum;
  logic [63:0] draw_word;
  logic [63:0] w2_x;
  logic [63:0] w3_x;
  logic [63:0] w1_x;
  logic [63:0] w0_x;

  // Splitmix counter step
  assign ctr_nxt = ctr_r + xsr_pkg::GOLDEN_GAMMA;

  // Partial product operand selection: lo*lo, lo*hi, hi*lo
  assign mul_const = cmd.stage ? xsr_pkg::MIX_MUL_B : xsr_pkg::MIX_MUL_A;
  assign mul_a     = (cmd.op == xsr_pkg::OP_MUL2) ? z_r[63:32] : z_r[31:0];
  assign mul_b     = (cmd.op == xsr_pkg::OP_MUL1) ? mul_const[63:32] : mul_const[31:0];

  // Last partial product folded into the high word
  assign mix_sum = acc_r + {prod_r[31:0], 32'd0};

  // xoshiro256++ output and state update
  assign draw_sum  = w_r[0] + w_r[3];
  assign draw_word = {draw_sum[40:0], draw_sum[63:41]} + w_r[0];
  assign w2_x      = w_r[2] ^ w_r[0];
  assign w3_x      = w_r[3] ^ w_r[1];
  assign w1_x      = w_r[1] ^ w2_x;
  assign w0_x      = w_r[0] ^ w3_x;

  // Seeding registers and state words
  always_ff @(posedge clk) begin
    case (cmd.op)
      xsr_pkg::OP_LOAD_SEED: begin
        ctr_r <= seed_value;
      end
      xsr_pkg::OP_LOAD_ZERO: begin
        ctr_r <= '0;
      end
      xsr_pkg::OP_GAMMA: begin
        ctr_r <= ctr_nxt;
        z_r   <= ctr_nxt ^ (ctr_nxt >> 30);
      end
      xsr_pkg::OP_MUL0: begin
        prod_r <= mul_a * mul_b;
      end
      xsr_pkg::OP_MUL1: begin
        acc_r  <= prod_r;
        prod_r <= mul_a * mul_b;
      end
      xsr_pkg::OP_MUL2: begin
        acc_r  <= acc_r + {prod_r[31:0], 32'd0};
        prod_r <= mul_a * mul_b;
      end
      xsr_pkg::OP_FIN: begin
        if (cmd.stage) begin
          w_r[cmd.word_idx] <= mix_sum ^ (mix_sum >> 31);
        end else begin
          z_r <= mix_sum ^ (mix_sum >> 27);
        end
      end
      xsr_pkg::OP_DRAW: begin
        w_r[0] <= w0_x;
        w_r[1] <= w1_x;
        w_r[2] <= w2_x ^ (w_r[1] << 17);
        w_r[3] <= {w3_x[18:0], w3_x[63:19]};
        word_r <= draw_word;
      end
      default: begin
      end
    endcase
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == xsr_pkg::OP_DRAW) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_busy           = out_valid_r && out_stall;
  assign out_valid              = out_valid_r;
  assign out_data.random_word   = word_r;
  assign out_data.unit_fraction = word_r[63:12];
  assign out_data.coin_bit      = word_r[0];

endmodule

`default_nettype wire

// ===== hdl/xsr_ctrl.sv =====
`default_nettype none

module xsr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_mode,
  output logic                  in_stall,
  input  wire xsr_pkg::dp_sts_t sts,
  output xsr_pkg::ctl_cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_GAMMA = 3'd2;
  localparam logic [2:0] ST_MUL0  = 3'd3;
  localparam logic [2:0] ST_MUL1  = 3'd4;
  localparam logic [2:0] ST_MUL2  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       stage_r;
  logic       stage_nxt;
  logic [1:0] word_r;
  logic [1:0] word_nxt;
  logic       accept;

  // Items are taken only when idle and the result slot can move
  assign in_stall = (state_r != ST_IDLE) || sts.out_busy;
  assign accept   = in_valid && !in_stall;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    stage_nxt    = stage_r;
    word_nxt     = word_r;
    cmd.op       = xsr_pkg::OP_NONE;
    cmd.stage    = stage_r;
    cmd.word_idx = word_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == xsr_pkg::MODE_DRAW) begin
            cmd.op = xsr_pkg::OP_DRAW;
          end else begin
            cmd.op    = xsr_pkg::OP_LOAD_SEED;
            word_nxt  = 2'd0;
            state_nxt = ST_GAMMA;
          end
        end
      end
      ST_INIT: begin
        cmd.op    = xsr_pkg::OP_LOAD_ZERO;
        word_nxt  = 2'd0;
        state_nxt = ST_GAMMA;
      end
      ST_GAMMA: begin
        cmd.op    = xsr_pkg::OP_GAMMA;
        stage_nxt = 1'b0;
        state_nxt = ST_MUL0;
      end
      ST_MUL0: begin
        cmd.op    = xsr_pkg::OP_MUL0;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.op    = xsr_pkg::OP_MUL1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.op    = xsr_pkg::OP_MUL2;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.op = xsr_pkg::OP_FIN;
        if (!stage_r) begin
          stage_nxt = 1'b1;
          state_nxt = ST_MUL0;
        end else if (word_r == 2'd3) begin
          state_nxt = ST_IDLE;
        end else begin
          word_nxt  = word_r + 2'd1;
          state_nxt = ST_GAMMA;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      stage_r <= 1'b0;
      word_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      word_r  <= word_nxt;
    end
  end

  // A draw leaves the sequencer idle
  a_draw_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == xsr_pkg::MODE_DRAW) |=> (state_r == ST_IDLE))
    else $error("draw beat left the sequencer busy");

  // A reseed starts filling at the first word
  a_reseed_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == xsr_pkg::MODE_RESEED) |=> (state_r == ST_GAMMA && word_r == 2'd0))
    else $error("reseed did not start at word zero");

  // Each word opens with the first mix multiply
  a_gamma_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GAMMA) |=> (state_r == ST_MUL0 && !stage_r))
    else $error("counter step not followed by first multiply");

  // The last word's second mix ends the reseed
  a_reseed_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && stage_r && word_r == 2'd3) |=> (state_r == ST_IDLE))
    else $error("reseed did not finish after fourth word");

endmodule

`default_nettype wire

// ===== hdl/xoshiro256pp_random_generator.sv =====
// xoshiro256++ generator with splitmix64 seeding. A draw beat (mode 1) is taken and its
// result appears in the output register on the next cycle; draws flow at one per cycle as
// long as the result side keeps up. A reseed beat (mode 0) gives no result and holds
// in_stall high while it fills the state: each of the four state words needs a counter
// step and two 64-bit multiplies, and each multiply is three 32x32 partial products
// through one shared multiplier, plus a closing add. After reset the block seeds itself
// with zero before the first beat is taken.
`default_nettype none

module xoshiro256pp_random_generator (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire xsr_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output xsr_pkg::out_item_t     out_data
);

  xsr_pkg::ctl_cmd_t cmd;
  xsr_pkg::dp_sts_t  sts;

  xsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  xsr_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .seed_value (in_data.seed_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
